[rtl/core/rrfh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfh_pkg
// Shared types and constants of the receive ring buffer with header hunt.
// ----------------------------------------------------------------------------
package rrfh_pkg;

    // Field widths of the stream payload
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    // Item kinds carried on the slave-side tuser
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_REQ  = 1'b1;

    // Frame header patterns: FF FF or F0 FE
    localparam logic [BYTE_W-1:0] HDR_FF = 8'hFF;
    localparam logic [BYTE_W-1:0] HDR_F0 = 8'hF0;
    localparam logic [BYTE_W-1:0] HDR_FE = 8'hFE;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HUNT_RD,
        ST_HUNT_CHK,
        ST_SEND_RD,
        ST_SEND_LOAD,
        ST_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_step;   // write zero at the clear pointer and advance it
        logic byte_wr;    // store the incoming byte unless full
        logic req_start;  // latch request length, reset counters
        logic hunt_drop;  // discard the current slot during the hunt
        logic send_load;  // take the current slot into the output register
        logic none_load;  // load a none-taken result
        logic finish;     // end of a served request
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_done;   // clear pointer is at the last slot
        logic fill_zero;  // buffer holds no byte
        logic len_zero;   // latched request length is zero
        logic hunt_stop;  // header found or hunt pass exhausted
        logic out_last;   // output register holds the final result
    } t_sts;

endpackage

[rtl/core/rrfh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfh_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rrfh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                       o_rdata_a,
    output logic [WIDTH-1:0]                       o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register both reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[rtl/core/rrfh_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfh_dp
// Datapath: ring RAM, read/write positions, fill count, hunt and request
// counters, and the output register.
// ----------------------------------------------------------------------------
module rrfh_dp #(
    parameter int BUF_DEPTH   = 256,
    parameter int MAX_REQUEST = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rrfh_pkg::t_cmd              i_cmd,
    output rrfh_pkg::t_sts              o_sts,
    input  logic [rrfh_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic [rrfh_pkg::LEN_W-1:0]  i_request_length,
    output logic [rrfh_pkg::BYTE_W-1:0] o_out_byte,
    output logic [rrfh_pkg::LEN_W-1:0]  o_out_count,
    output logic                        o_is_last,
    output logic                        o_none_taken
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int FW = $clog2(BUF_DEPTH + 1);

    logic [AW-1:0]                r_rp, n_rp;
    logic [AW-1:0]                r_wp, n_wp;
    logic [AW-1:0]                r_clr, n_clr;
    logic [FW-1:0]                r_fill, n_fill;
    logic [FW-1:0]                r_step, n_step;
    logic [rrfh_pkg::LEN_W-1:0]   r_len, n_len;
    logic [rrfh_pkg::LEN_W-1:0]   r_got, n_got;
    logic [rrfh_pkg::BYTE_W-1:0]  r_out_byte, n_out_byte;
    logic [rrfh_pkg::LEN_W-1:0]   r_out_count, n_out_count;
    logic                         r_out_last, n_out_last;
    logic                         r_out_none, n_out_none;

    logic [AW-1:0]                rp_inc;
    logic [AW-1:0]                wp_inc;
    logic [FW-1:0]                fill_dec;
    logic                         full;
    logic [rrfh_pkg::LEN_W-1:0]   len_sat;
    logic [rrfh_pkg::LEN_W-1:0]   got_inc;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [rrfh_pkg::BYTE_W-1:0]  ram_wdata;
    logic [rrfh_pkg::BYTE_W-1:0]  cur_byte;
    logic [rrfh_pkg::BYTE_W-1:0]  nxt_byte;
    logic                         hdr_match;

    // Position, count and length helpers
    assign rp_inc   = (r_rp == AW'(BUF_DEPTH - 1)) ? '0 : r_rp + AW'(1);
    assign wp_inc   = (r_wp == AW'(BUF_DEPTH - 1)) ? '0 : r_wp + AW'(1);
    assign fill_dec = (r_fill != '0) ? r_fill - FW'(1) : '0;
    assign full     = (r_fill == FW'(BUF_DEPTH));
    assign len_sat  = (i_request_length > rrfh_pkg::LEN_W'(MAX_REQUEST))
                    ? rrfh_pkg::LEN_W'(MAX_REQUEST) : i_request_length;
    assign got_inc  = r_got + rrfh_pkg::LEN_W'(1);

    // Ring RAM write port: clear sweep, byte store, or slot clear on read
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_rp;
        ram_wdata = '0;
        priority if (i_cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
        end else if (i_cmd.byte_wr && !full) begin
            ram_we    = 1'b1;
            ram_waddr = r_wp;
            ram_wdata = i_rx_byte;
        end else if (i_cmd.hunt_drop || i_cmd.send_load) begin
            ram_we    = 1'b1;
        end
    end

    rrfh_ram #(
        .WIDTH (rrfh_pkg::BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (r_rp),
        .i_raddr_b (rp_inc),
        .o_rdata_a (cur_byte),
        .o_rdata_b (nxt_byte)
    );

    // Header check on the current and next slot
    assign hdr_match = ((cur_byte == rrfh_pkg::HDR_FF) && (nxt_byte == rrfh_pkg::HDR_FF))
                    || ((cur_byte == rrfh_pkg::HDR_F0) && (nxt_byte == rrfh_pkg::HDR_FE));

    // Next values
    always_comb begin
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_clr       = r_clr;
        n_fill      = r_fill;
        n_step      = r_step;
        n_len       = r_len;
        n_got       = r_got;
        n_out_byte  = r_out_byte;
        n_out_count = r_out_count;
        n_out_last  = r_out_last;
        n_out_none  = r_out_none;

        if (i_cmd.clr_step) begin
            n_clr = r_clr + AW'(1);
        end
        if (i_cmd.byte_wr && !full) begin
            n_fill = r_fill + FW'(1);
            n_wp   = wp_inc;
        end
        if (i_cmd.req_start) begin
            n_len  = len_sat;
            n_got  = '0;
            n_step = '0;
        end
        if (i_cmd.hunt_drop) begin
            n_fill = fill_dec;
            n_rp   = rp_inc;
            n_step = r_step + FW'(1);
        end
        if (i_cmd.send_load) begin
            n_out_byte  = cur_byte;
            n_out_count = got_inc;
            n_out_last  = (r_fill == FW'(1)) || (got_inc == r_len);
            n_out_none  = 1'b0;
            n_fill      = fill_dec;
            n_rp        = rp_inc;
            n_got       = got_inc;
        end
        if (i_cmd.none_load) begin
            n_out_byte  = '0;
            n_out_count = '0;
            n_out_last  = 1'b1;
            n_out_none  = 1'b1;
        end
        // Rewind both positions once the buffer runs dry
        if (i_cmd.finish && (r_fill == '0)) begin
            n_rp = '0;
            n_wp = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp   <= '0;
            r_wp   <= '0;
            r_clr  <= '0;
            r_fill <= '0;
            r_step <= '0;
            r_got  <= '0;
        end else begin
            r_rp   <= n_rp;
            r_wp   <= n_wp;
            r_clr  <= n_clr;
            r_fill <= n_fill;
            r_step <= n_step;
            r_got  <= n_got;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_len       <= n_len;
        r_out_byte  <= n_out_byte;
        r_out_count <= n_out_count;
        r_out_last  <= n_out_last;
        r_out_none  <= n_out_none;
    end

    assign o_sts.clr_done  = (r_clr == AW'(BUF_DEPTH - 1));
    assign o_sts.fill_zero = (r_fill == '0);
    assign o_sts.len_zero  = (r_len == '0);
    assign o_sts.hunt_stop = hdr_match || (r_step == FW'(BUF_DEPTH));
    assign o_sts.out_last  = r_out_last;

    assign o_out_byte   = r_out_byte;
    assign o_out_count  = r_out_count;
    assign o_is_last    = r_out_last;
    assign o_none_taken = r_out_none;

endmodule

[rtl/core/rrfh_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrfh_ctrl
// Controller: clearing pass, byte stores, header hunt and result sequencing.
// ----------------------------------------------------------------------------
module rrfh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_mode,
    input  logic           i_module_ready,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  rrfh_pkg::t_sts i_sts,
    output rrfh_pkg::t_cmd o_cmd
);

    rrfh_pkg::t_state r_state, n_state;
    logic             r_served, n_served;
    logic             req_acc;

    assign req_acc = i_in_valid && (i_in_mode == rrfh_pkg::MODE_REQ);

    // Next state
    always_comb begin
        n_state  = r_state;
        n_served = r_served;
        unique case (r_state)
            rrfh_pkg::ST_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = rrfh_pkg::ST_IDLE;
                end
            end
            rrfh_pkg::ST_IDLE: begin
                if (req_acc) begin
                    n_served = i_module_ready;
                    n_state  = i_module_ready ? rrfh_pkg::ST_HUNT_RD : rrfh_pkg::ST_OUT;
                end
            end
            rrfh_pkg::ST_HUNT_RD: begin
                n_state = rrfh_pkg::ST_HUNT_CHK;
            end
            rrfh_pkg::ST_HUNT_CHK: begin
                n_state = i_sts.hunt_stop ? rrfh_pkg::ST_SEND_RD : rrfh_pkg::ST_HUNT_RD;
            end
            rrfh_pkg::ST_SEND_RD: begin
                if (i_sts.fill_zero || i_sts.len_zero) begin
                    n_state = rrfh_pkg::ST_OUT;
                end else begin
                    n_state = rrfh_pkg::ST_SEND_LOAD;
                end
            end
            rrfh_pkg::ST_SEND_LOAD: begin
                n_state = rrfh_pkg::ST_OUT;
            end
            rrfh_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_state = i_sts.out_last ? rrfh_pkg::ST_IDLE : rrfh_pkg::ST_SEND_RD;
                end
            end
            default: begin
                n_state = rrfh_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            rrfh_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            rrfh_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.byte_wr   = i_in_valid && (i_in_mode == rrfh_pkg::MODE_BYTE);
                o_cmd.req_start = req_acc;
                o_cmd.none_load = req_acc && !i_module_ready;
            end
            rrfh_pkg::ST_HUNT_RD: begin
            end
            rrfh_pkg::ST_HUNT_CHK: begin
                o_cmd.hunt_drop = !i_sts.hunt_stop;
            end
            rrfh_pkg::ST_SEND_RD: begin
                o_cmd.none_load = i_sts.fill_zero || i_sts.len_zero;
            end
            rrfh_pkg::ST_SEND_LOAD: begin
                o_cmd.send_load = 1'b1;
            end
            rrfh_pkg::ST_OUT: begin
                o_out_valid  = 1'b1;
                o_cmd.finish = i_out_ready && i_sts.out_last && r_served;
            end
            default: begin
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rrfh_pkg::ST_CLEAR;
            r_served <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_served <= n_served;
        end
    end

endmodule

[rtl/core/rx_ring_frame_hunt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_ring_frame_hunt
// Receive ring buffer with frame-header hunt: stores received bytes and
// answers read requests after skipping to an FF FF or F0 FE header.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                       | tuser      | tlast
//  s_axis   | in  | rx_byte, request_length, module_ready    | mode       | -
//  m_axis   | out | out_byte, out_count, 1 zero pad bit      | none_taken | is_last
//
// After reset a clearing pass writes zero to every ring slot, with
// s_axis_tready low. A served request is accepted, then runs one header
// check per discarded slot plus the final one, each a registered RAM read
// of the current and next slot (ST_HUNT_RD) then the check (ST_HUNT_CHK);
// each returned byte then passes ST_SEND_RD, ST_SEND_LOAD and ST_OUT, where
// m_axis may stall it. A request returning nothing goes from acceptance to
// ST_OUT when the module is not ready, else via the hunt and ST_SEND_RD.
// s_axis_tready is low from request acceptance until its final result is taken.
// ----------------------------------------------------------------------------
module rx_ring_frame_hunt #(
    parameter int BUF_DEPTH   = 256,
    parameter int MAX_REQUEST = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [14:8] request_length,
                                        // [15] module_ready
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [14:8] out_count,
                                        // [15] zero
    output logic        m_axis_tuser,   // none_taken
    output logic        m_axis_tlast    // is_last
);

    rrfh_pkg::t_cmd              cmd;
    rrfh_pkg::t_sts              sts;
    logic [rrfh_pkg::BYTE_W-1:0] out_byte;
    logic [rrfh_pkg::LEN_W-1:0]  out_count;

    rrfh_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .i_in_mode      (s_axis_tuser),
        .i_module_ready (s_axis_tdata[15]),
        .o_in_ready     (s_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    rrfh_dp #(
        .BUF_DEPTH   (BUF_DEPTH),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_rx_byte        (s_axis_tdata[7:0]),
        .i_request_length (s_axis_tdata[14:8]),
        .o_out_byte       (out_byte),
        .o_out_count      (out_count),
        .o_is_last        (m_axis_tlast),
        .o_none_taken     (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, out_count, out_byte};

endmodule
